[src/bvce_pkg.sv]
package bvce_pkg;

	localparam int DIVIDEND_W = 24;
	localparam int DIVISOR_W  = 12;
	localparam int ADDR_W     = 4;

	localparam logic [11:0] CONV_MUL  = 12'd3100;
	localparam logic [11:0] SEG_RECIP = 12'd1311;

	localparam logic [13:0] MV_FULL   = 14'd4200;
	localparam logic [13:0] MV_EMPTY  = 14'd3300;
	localparam logic [13:0] MV_CLAMP  = 14'd16383;
	localparam logic [6:0]  PCT_FULL  = 7'd100;
	localparam logic [6:0]  PCT_EMPTY = 7'd0;

	localparam int CURVE_POINTS = 10;

	localparam logic [1:0] REG_MONITOR = 2'd0;
	localparam logic [1:0] REG_COARSE  = 2'd1;
	localparam logic [1:0] REG_RATIO   = 2'd2;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	function automatic logic [13:0] curve_mv(input logic [3:0] idx);
		logic [13:0] v;
		case (idx)
			4'd0:    v = 14'd4200;
			4'd1:    v = 14'd4100;
			4'd2:    v = 14'd4000;
			4'd3:    v = 14'd3900;
			4'd4:    v = 14'd3800;
			4'd5:    v = 14'd3700;
			4'd6:    v = 14'd3600;
			4'd7:    v = 14'd3500;
			4'd8:    v = 14'd3400;
			4'd9:    v = 14'd3300;
			default: v = 14'd3300;
		endcase
		return v;
	endfunction

	function automatic logic [6:0] curve_pct(input logic [3:0] idx);
		logic [6:0] v;
		case (idx)
			4'd0:    v = 7'd100;
			4'd1:    v = 7'd90;
			4'd2:    v = 7'd80;
			4'd3:    v = 7'd60;
			4'd4:    v = 7'd45;
			4'd5:    v = 7'd30;
			4'd6:    v = 7'd18;
			4'd7:    v = 7'd10;
			4'd8:    v = 7'd5;
			4'd9:    v = 7'd0;
			default: v = 7'd0;
		endcase
		return v;
	endfunction

endpackage

[src/bvce_divider.sv]
module bvce_divider (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bvce_pkg::div_req_t                  req,
	output logic                                done,
	output logic [bvce_pkg::DIVIDEND_W-1:0]     quotient
);

	localparam int W  = bvce_pkg::DIVIDEND_W;
	localparam int DW = bvce_pkg::DIVISOR_W;
	localparam logic [4:0] LAST_STEP = 5'(W - 1);

	logic [W-1:0]  work_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] divisor_q;
	logic [4:0]    cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0]   shifted;
	logic [DW:0]   trial;
	logic          fits;

	assign shifted = {rem_q, work_q[W-1]};
	assign trial   = shifted - {1'b0, divisor_q};
	assign fits    = shifted >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q    <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			work_q <= {work_q[W-2:0], fits};
			rem_q  <= fits ? trial[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

[src/battery_voltage_and_charge_estimator_core.sv]
// a sample with sample_ok low or in millivolt mode passes through the accumulate step only; a
// coarse sample first takes a conversion step for the multiply and shift-add scaling by 3100/4095
// the last attempt of a burst, when its result is valid, adds the 24-step radix-2 mean divide,
// then the scale step, the curve step and, strictly between the end points, the interpolation step
// one item at a time; a held result keeps the input stalled
// reset (arst_n low) clears accumulators and sequencer, loads monitor off, coarse on, ratio 2
module battery_voltage_and_charge_estimator_core #(
	parameter int BURST_LENGTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bvce_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [11:0]                 sample_value,
	input  logic                        sample_ok,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        reading_valid,
	output logic [13:0]                 battery_mv,
	output logic [6:0]                  charge_percent
);

	localparam logic [3:0] LAST = 4'(BURST_LENGTH - 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CONV   = 3'd1;
	localparam logic [2:0] S_ACC    = 3'd2;
	localparam logic [2:0] S_MEAN   = 3'd3;
	localparam logic [2:0] S_SCALE  = 3'd4;
	localparam logic [2:0] S_SOC    = 3'd5;
	localparam logic [2:0] S_INTERP = 3'd6;
	localparam logic [2:0] S_OUT    = 3'd7;

	logic [2:0]  state_q;
	logic        monitor_q;
	logic        coarse_q;
	logic [2:0]  ratio_q;
	logic [3:0]  attempt_q;
	logic [15:0] sum_q;
	logic [4:0]  cnt_q;
	logic [11:0] sample_q;
	logic        ok_q;
	logic        conv_q;
	logic [11:0] conv_mv_q;
	logic [11:0] prod_q;
	logic        rv_q;
	logic [13:0] bmv_q;
	logic [6:0]  pct_q;

	bvce_pkg::div_req_t                  div_req;
	logic                                div_done;
	logic [bvce_pkg::DIVIDEND_W-1:0]     div_quo;

	logic        cfg_wr;
	logic [23:0] conv_prod;
	logic [23:0] conv_sum;
	logic [11:0] add_mv;
	logic [15:0] sum_next;
	logic [4:0]  cnt_next;
	logic        result_ok;
	logic [2:0]  ratio_eff;
	logic [14:0] scaled;
	logic [3:0]  seg;
	logic [13:0] seg_lo_mv;
	logic [6:0]  seg_lo_pct;
	logic [4:0]  seg_rise;
	logic [13:0] seg_diff;
	logic [11:0] seg_prod;
	logic [23:0] interp_prod;
	logic        soc_mid;

	bvce_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			monitor_q <= 1'b0;
			coarse_q  <= 1'b1;
			ratio_q   <= 3'd2;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				bvce_pkg::REG_MONITOR: monitor_q <= pwdata[0];
				bvce_pkg::REG_COARSE:  coarse_q  <= pwdata[0];
				bvce_pkg::REG_RATIO:   ratio_q   <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			bvce_pkg::REG_MONITOR: prdata = {31'b0, monitor_q};
			bvce_pkg::REG_COARSE:  prdata = {31'b0, coarse_q};
			bvce_pkg::REG_RATIO:   prdata = {29'b0, ratio_q};
			default:               prdata = '0;
		endcase
	end

	// coarse scaling: divide by 4095 as (x + (x >> 12) + 1) >> 12
	assign conv_prod = {12'b0, sample_q} * {12'b0, bvce_pkg::CONV_MUL};
	assign conv_sum  = conv_prod + {12'b0, conv_prod[23:12]} + 24'd1;

	// accumulation
	assign add_mv    = conv_q ? conv_mv_q : sample_q;
	assign sum_next  = ok_q ? sum_q + {4'b0, add_mv} : sum_q;
	assign cnt_next  = ok_q ? cnt_q + 5'd1 : cnt_q;
	assign result_ok = monitor_q && (cnt_next != 5'd0);

	assign ratio_eff = (ratio_q == 3'd0) ? 3'd1 : ((ratio_q > 3'd4) ? 3'd4 : ratio_q);
	assign scaled    = {3'b0, div_quo[11:0]} * {12'b0, ratio_eff};

	// curve segment: lowest index whose lower point is at or below the voltage
	always_comb begin
		seg = 4'd8;
		for (int i = 8; i >= 0; i--) begin
			if (bmv_q >= bvce_pkg::curve_mv(4'(i + 1))) seg = 4'(i);
		end
	end

	assign seg_lo_mv  = bvce_pkg::curve_mv(seg + 4'd1);
	assign seg_lo_pct = bvce_pkg::curve_pct(seg + 4'd1);
	assign seg_rise   = 5'(bvce_pkg::curve_pct(seg) - seg_lo_pct);
	assign seg_diff   = bmv_q - seg_lo_mv;
	assign seg_prod   = {5'b0, seg_diff[6:0]} * {7'b0, seg_rise};
	assign soc_mid    = (bmv_q < bvce_pkg::MV_FULL) && (bmv_q > bvce_pkg::MV_EMPTY);

	// segment span of 100 mv: divide by reciprocal 1311 / 2^17
	assign interp_prod = {12'b0, prod_q} * {12'b0, bvce_pkg::SEG_RECIP};

	always_comb begin
		div_req = '0;
		case (state_q)
			S_ACC: begin
				if (!(attempt_q < LAST) && result_ok) begin
					div_req.start    = 1'b1;
					div_req.dividend = {8'b0, sum_next};
					div_req.divisor  = {7'b0, cnt_next};
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			attempt_q <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= (sample_ok && coarse_q) ? S_CONV : S_ACC;
				end
				S_CONV: state_q <= S_ACC;
				S_ACC: begin
					if (attempt_q < LAST) begin
						attempt_q <= attempt_q + 4'd1;
						sum_q     <= sum_next;
						cnt_q     <= cnt_next;
						state_q   <= S_IDLE;
					end else begin
						attempt_q <= '0;
						sum_q     <= '0;
						cnt_q     <= '0;
						state_q   <= result_ok ? S_MEAN : S_OUT;
					end
				end
				S_MEAN: begin
					if (div_done) state_q <= S_SCALE;
				end
				S_SCALE:  state_q <= S_SOC;
				S_SOC:    state_q <= soc_mid ? S_INTERP : S_OUT;
				S_INTERP: state_q <= S_OUT;
				S_OUT: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					sample_q <= sample_value;
					ok_q     <= sample_ok;
					conv_q   <= coarse_q;
				end
			end
			S_CONV: begin
				conv_mv_q <= conv_sum[23:12];
			end
			S_ACC: begin
				if (!(attempt_q < LAST) && !result_ok) begin
					rv_q  <= 1'b0;
					bmv_q <= '0;
					pct_q <= '0;
				end
			end
			S_SCALE: begin
				rv_q  <= 1'b1;
				bmv_q <= (scaled > {1'b0, bvce_pkg::MV_CLAMP}) ? bvce_pkg::MV_CLAMP
				                                                : scaled[13:0];
			end
			S_SOC: begin
				prod_q <= seg_prod;
				if (bmv_q >= bvce_pkg::MV_FULL)       pct_q <= bvce_pkg::PCT_FULL;
				else if (bmv_q <= bvce_pkg::MV_EMPTY) pct_q <= bvce_pkg::PCT_EMPTY;
				else                                  pct_q <= seg_lo_pct;
			end
			S_INTERP: begin
				pct_q <= pct_q + interp_prod[23:17];
			end
			default: ;
		endcase
	end

	assign in_stall       = state_q != S_IDLE;
	assign out_valid      = state_q == S_OUT;
	assign reading_valid  = rv_q;
	assign battery_mv     = bmv_q;
	assign charge_percent = pct_q;

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");

	a_item_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("ready again right after a transfer");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reading_valid |-> battery_mv == 14'd0 && charge_percent == 7'd0)
		else $error("invalid result carries nonzero fields");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> charge_percent <= bvce_pkg::PCT_FULL)
		else $error("charge above full scale");

endmodule

[bench/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        valid;
		logic [13:0] mv;
		logic [6:0]  pct;
	} reading_t;

	class soc_predictor;
		logic        monitor_on;
		logic        coarse_on;
		logic [2:0]  ratio;
		logic [3:0]  attempts;
		logic [15:0] mv_sum;
		logic [4:0]  good_count;
		int unsigned knee_mv[10];
		int unsigned knee_pct[10];
		reading_t    expected_readings[$];
		int unsigned mismatches;
		int unsigned samples_taken;
		int unsigned readings_compared;

		function new();
			knee_mv = '{4200, 4100, 4000, 3900, 3800, 3700, 3600, 3500, 3400, 3300};
			knee_pct = '{100, 90, 80, 60, 45, 30, 18, 10, 5, 0};
			monitor_on = 1'b0;
			coarse_on = 1'b1;
			ratio = 3'd2;
			attempts = '0;
			mv_sum = '0;
			good_count = '0;
			mismatches = 0;
			samples_taken = 0;
			readings_compared = 0;
		endfunction

		function void set_register(logic [1:0] index, logic [31:0] data);
			case (index)
				bvce_pkg::REG_MONITOR: monitor_on = data[0];
				bvce_pkg::REG_COARSE:  coarse_on = data[0];
				bvce_pkg::REG_RATIO:   ratio = data[2:0];
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return expected_readings.size();
		endfunction

		function int unsigned charge_of(int unsigned mv);
			if (mv >= knee_mv[0])
				return 100;
			if (mv <= knee_mv[9])
				return 0;
			for (int i = 0; i < 9; i++) begin
				if (mv <= knee_mv[i] && mv >= knee_mv[i+1])
					return knee_pct[i+1] + ((mv - knee_mv[i+1]) *
						(knee_pct[i] - knee_pct[i+1])) / (knee_mv[i] - knee_mv[i+1]);
			end
			return 0;
		endfunction

		function void take_sample(logic [11:0] value, logic ok);
			int unsigned mv;
			int unsigned r;
			int unsigned bmv;
			reading_t    next;
			samples_taken++;
			if (ok) begin
				mv = 32'(value);
				if (coarse_on)
					mv = (mv * 3100) / 4095;
				mv_sum = mv_sum + 16'(mv);
				good_count = good_count + 5'd1;
			end
			if (attempts != 4'd15) begin
				attempts = attempts + 4'd1;
				return;
			end
			next.valid = monitor_on && good_count != 0;
			next.mv = '0;
			next.pct = '0;
			if (next.valid) begin
				r = (ratio == 3'd0) ? 1 : (ratio > 3'd4) ? 4 : ratio;
				bmv = (int'(mv_sum) / int'(good_count)) * r;
				if (bmv > 16383)
					bmv = 16383;
				next.mv = 14'(bmv);
				next.pct = 7'(charge_of(bmv));
			end
			expected_readings.push_back(next);
			attempts = '0;
			mv_sum = '0;
			good_count = '0;
		endfunction

		function void compare_reading(logic valid, logic [13:0] mv, logic [6:0] pct);
			reading_t want;
			if (expected_readings.size() == 0) begin
				$display("%0t: unexpected reading: valid %0d, mv %0d, percent %0d",
					$time, valid, mv, pct);
				mismatches++;
				return;
			end
			want = expected_readings.pop_front();
			readings_compared++;
			if (valid !== want.valid) begin
				$display("%0t: reading_valid expected %0d, actual %0d", $time, want.valid, valid);
				mismatches++;
			end
			if (mv !== want.mv) begin
				$display("%0t: battery_mv expected %0d, actual %0d", $time, want.mv, mv);
				mismatches++;
			end
			if (pct !== want.pct) begin
				$display("%0t: charge_percent expected %0d, actual %0d", $time, want.pct, pct);
				mismatches++;
			end
		endfunction

		function void report_leftovers();
			if (expected_readings.size() != 0) begin
				$display("%0t: %0d expected readings never arrived", $time,
					expected_readings.size());
				mismatches++;
			end
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [bvce_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0]                 pwdata = '0;
	logic [31:0]                 prdata;
	logic                        pready;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [11:0]                 sample_value = '0;
	logic                        sample_ok = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic                        reading_valid;
	logic [13:0]                 battery_mv;
	logic [6:0]                  charge_percent;

	soc_predictor sb = new();

	bit          idle_on = 1'b1;
	int unsigned sent;
	int unsigned writes_done;
	int unsigned hold_requests;
	int unsigned holds_served;
	int unsigned hold_left;

	battery_voltage_and_charge_estimator_core dut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.compare_reading(reading_valid, battery_mv, charge_percent);
			if (in_valid && !in_stall)
				sb.take_sample(sample_value, sample_ok);
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_left = 1500;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_on && ($urandom_range(99) < 16);
		end
	end

	initial begin
		#800_000;
		$display("run stopped at the time limit");
		$display("FAIL");
		$finish;
	end

	task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(index, data);
		writes_done++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input logic mon, input logic coarse, input logic [2:0] r);
		write_reg(bvce_pkg::REG_MONITOR, {31'd0, mon});
		write_reg(bvce_pkg::REG_COARSE, {31'd0, coarse});
		write_reg(bvce_pkg::REG_RATIO, {29'd0, r});
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		repeat (100) @(negedge clk);
	endtask

	task automatic send_sample(input logic [11:0] value, input logic ok);
		while (idle_on && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_value <= value;
		sample_ok <= ok;
		do @(posedge clk); while (in_stall);
		sent++;
		@(negedge clk);
	endtask

	function automatic int unsigned level_for(int unsigned target);
		int unsigned r;
		int unsigned v;
		r = (sb.ratio == 3'd0) ? 1 : (sb.ratio > 3'd4) ? 4 : sb.ratio;
		v = target / r;
		if (sb.coarse_on)
			v = (v * 4095 + 3099) / 3100;
		return (v > 4095) ? 4095 : v;
	endfunction

	initial begin
		int unsigned phase_items;
		int unsigned n;
		int unsigned kind;
		int unsigned target;
		int unsigned lvl;
		int unsigned drain_wait;
		int          v;
		logic        ok;
		logic [15:0] good_mask;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults keep the monitor off
		for (int k = 0; k < 16; k++)
			send_sample(k == 0 ? 12'd0 : k == 1 ? 12'hFFF : {k[3:0], ~k[3:0], k[3:0]}, k != 5);
		settle();
		configure(1'b1, 1'b0, 3'd4);
		for (int k = 0; k < 16; k++)
			send_sample(12'hFFF, k == 15);

		for (int p = 0; p < 10; p++) begin
			settle();
			case (p)
				0: configure(1'b1, 1'b0, 3'd1);
				1: configure(1'b1, 1'b1, 3'd2);
				2: configure(1'b1, 1'b0, 3'd4);
				3: configure(1'b0, 1'b1, 3'd3);
				4: configure(1'b1, 1'b0, 3'd0);
				5: configure(1'b1, 1'b0, 3'd1);
				6: configure(1'b1, 1'b1, 3'd7);
				7: configure(1'b1, 1'b0, 3'd5);
				8: configure(1'b1, 1'b1, 3'd6);
				default: configure(1'($urandom_range(1)), 1'($urandom_range(1)),
					3'($urandom_range(7)));
			endcase
			idle_on = (p != 7);
			if (p == 5)
				hold_requests++;
			phase_items = 88 + $urandom_range(8);
			n = 0;
			while (n < phase_items) begin
				kind = $urandom_range(99);
				case ($urandom_range(2))
					0: target = sb.knee_mv[$urandom_range(9)] + $urandom_range(2) - 1;
					1: target = 3000 + $urandom_range(1500);
					default: target = $urandom_range(16383);
				endcase
				lvl = level_for(target);
				good_mask = '0;
				repeat (1 + $urandom_range(2)) good_mask[$urandom_range(15)] = 1'b1;
				for (int k = sent % 16; k < 16 && n < phase_items; k++) begin
					if (p == 8 && n == 40) begin
						in_valid <= 1'b0;
						do @(negedge clk); while (sb.pending() != 0);
					end
					if (kind < 15) begin
						v = int'(lvl);
						ok = 1'b1;
					end else if (kind < 30) begin
						v = int'(lvl) + int'($urandom_range(6)) - 3;
						v = (v < 0) ? 0 : (v > 4095) ? 4095 : v;
						ok = 1'b1;
					end else if (kind < 50) begin
						v = int'(lvl);
						ok = good_mask[k];
					end else if (kind < 60) begin
						v = int'($urandom_range(4095));
						ok = 1'b0;
					end else begin
						v = int'($urandom_range(4095));
						ok = ($urandom_range(99) < 80);
					end
					send_sample(12'(v), ok);
					n++;
				end
			end
		end

		in_valid <= 1'b0;
		drain_wait = 0;
		while (sb.pending() != 0 && drain_wait < 20000) begin
			@(negedge clk);
			drain_wait++;
		end
		repeat (100) @(negedge clk);
		sb.report_leftovers();
		$display("covered %0d sample transfers and %0d readings over %0d register writes",
			sb.samples_taken, sb.readings_compared, writes_done);
		$display("both conversion modes, divider ratios 0 to 7, monitor on and off, curve knees");
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
